// ===== src/acbc_pkg.sv =====
// Shared types, constants and AES helper functions for the two-lane CBC encryptor.
`default_nettype none
package acbc_pkg;

    localparam int RK_DEPTH = 15;
    localparam int RK_AW    = $clog2(RK_DEPTH);
    localparam int RK_W     = 128;

    localparam logic [2:0] CFG_KEY_SIZE  = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD0 = 3'd1;
    localparam logic [2:0] CFG_KEY_WORD1 = 3'd2;
    localparam logic [2:0] CFG_KEY_WORD2 = 3'd3;
    localparam logic [2:0] CFG_KEY_WORD3 = 3'd4;

    localparam logic OP_LOAD_IV = 1'b0;
    localparam logic OP_ENCRYPT = 1'b1;

    // Write bundle from the key schedule into the round-key memory.
    typedef struct packed {
        logic             en;
        logic [RK_AW-1:0] addr;
        logic [RK_W-1:0]  data;
    } rk_wr_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // One AES round without the key addition; byte 0 sits in bits 127..120.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0]   a [16];
        logic [7:0]   t [16];
        logic [7:0]   all;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            a[i] = s[127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) begin
            t[i] = SBOX[a[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)]];
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                a[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
                a[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
                a[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
                a[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
            end
        end else begin
            for (int i = 0; i < 16; i++) begin
                a[i] = t[i];
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = a[i];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/acbc_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
`default_nettype none
module acbc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/acbc_key_sched.sv =====
// AES key expansion, one schedule word per cycle, writing full round keys to memory.
`default_nettype none
module acbc_key_sched
    import acbc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [1:0]  key_size,
    input  wire logic [63:0] key_word0,
    input  wire logic [63:0] key_word1,
    input  wire logic [63:0] key_word2,
    input  wire logic [63:0] key_word3,
    output logic             done,
    output rk_wr_t           rk_wr
);
    logic        run_reg, run_next;
    logic [5:0]  idx_reg, idx_next;
    logic [2:0]  mod_reg, mod_next;
    logic [3:0]  nk_reg, nk_next;
    logic [7:0]  rc_reg, rc_next;
    logic [31:0] win_reg [8];
    logic [31:0] new_word, t, key_w;
    logic [63:0] kw;
    logic [2:0]  back_sel;

    always_comb begin
        unique case (idx_reg[2:1])
            2'd0: kw = key_word0;
            2'd1: kw = key_word1;
            2'd2: kw = key_word2;
            default: kw = key_word3;
        endcase
        key_w    = idx_reg[0] ? kw[31:0] : kw[63:32];
        back_sel = 3'(nk_reg - 4'd1);
        t        = win_reg[0];
        rc_next  = rc_reg;
        if (mod_reg == 3'd0) begin
            t = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rc_reg, 24'd0};
        end else if (nk_reg == 4'd8 && mod_reg == 3'd4) begin
            t = sub_word(win_reg[0]);
        end
        if ({1'b0, idx_reg} < {3'd0, nk_reg}) begin
            new_word = key_w;
        end else begin
            new_word = win_reg[back_sel] ^ t;
            if (run_reg && mod_reg == 3'd0) begin
                rc_next = xtime(rc_reg);
            end
        end
        mod_next = ({1'b0, mod_reg} == nk_reg - 4'd1) ? 3'd0 : mod_reg + 3'd1;
        idx_next = idx_reg + 6'd1;
        run_next = run_reg && idx_reg != 6'd59;
        nk_next  = nk_reg;
        if (start && !run_reg) begin
            run_next = 1'b1;
            idx_next = 6'd0;
            mod_next = 3'd0;
            rc_next  = 8'h01;
            unique case (key_size)
                2'd0: nk_next = 4'd4;
                2'd1: nk_next = 4'd6;
                default: nk_next = 4'd8;
            endcase
        end else if (!run_reg) begin
            idx_next = idx_reg;
            mod_next = mod_reg;
        end
        done         = run_reg && idx_reg == 6'd59;
        rk_wr.en     = run_reg && idx_reg[1:0] == 2'd3;
        rk_wr.addr   = idx_reg[5:2];
        rk_wr.data   = {win_reg[2], win_reg[1], win_reg[0], new_word};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
        end
        idx_reg <= idx_next;
        mod_reg <= mod_next;
        nk_reg  <= nk_next;
        rc_reg  <= rc_next;
        if (run_reg) begin
            win_reg[0] <= new_word;
            for (int j = 1; j < 8; j++) begin
                win_reg[j] <= win_reg[j-1];
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/aes_cbc_encrypt_two_lane.sv =====
// Top level of the two-lane AES-CBC encryptor.
//
//  Channel   Direction  Transfer condition        Payload
//  s_        in         s_tvalid & s_tready       tdata lanes, tuser opcode, tlast
//  m_        out        m_tvalid & m_tready       tdata ciphertext lanes, tlast
//  cfg_      in         cfg_wr_en                 key size and key words
//
// An encrypt transfer runs rounds 0 to nr (nr is 10, 12 or 14) in ST_ENC and then
// passes through ST_WAIT before its result is offered; the single round unit per lane
// iterates once per cycle, its round key read from the round-key memory in the previous cycle.
// An IV-load transfer runs the key schedule, one word per cycle, over all 60 schedule words.
// Reset is synchronous and active low; it clears control state and the chaining values.
// A stalled result waits in the output register; a finished encrypt waits for it.
`default_nettype none
module aes_cbc_encrypt_two_lane
    import acbc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // lane0_hi [63:0], lane0_lo [127:64], lane1_hi [191:128], lane1_lo [255:192]
    input  wire logic [255:0] s_tdata,
    // opcode [0]
    input  wire logic         s_tuser,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // lane0_out_hi [63:0], lane0_out_lo [127:64], lane1_out_hi [191:128],
    // lane1_out_lo [255:192]
    output logic      [255:0] m_tdata,
    output logic              m_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_wdata
);
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXPAND = 2'd1;
    localparam logic [1:0] ST_ENC    = 2'd2;
    localparam logic [1:0] ST_WAIT   = 2'd3;

    logic [1:0]   key_size_reg;
    logic [63:0]  key_word0_reg, key_word1_reg, key_word2_reg, key_word3_reg;

    logic [1:0]   state_reg, state_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [127:0] chain0_reg, chain0_next, chain1_reg, chain1_next;
    logic [127:0] s0_reg, s0_next, s1_reg, s1_next;
    logic         last_reg, last_next;
    logic         m_valid_reg, m_valid_next;
    logic [255:0] m_data_reg, m_data_next;
    logic         m_last_reg, m_last_next;

    logic [3:0]      nr;
    logic            accept, ks_start, ks_done, out_free;
    logic [RK_AW-1:0] rd_addr;
    logic [RK_W-1:0]  rk_data;
    rk_wr_t           rk_wr;

    // Configuration registers; the user must write them only while idle, the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_size_reg  <= 2'd0;
            key_word0_reg <= 64'd0;
            key_word1_reg <= 64'd0;
            key_word2_reg <= 64'd0;
            key_word3_reg <= 64'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_KEY_SIZE:  key_size_reg  <= cfg_wdata[1:0];
                CFG_KEY_WORD0: key_word0_reg <= cfg_wdata;
                CFG_KEY_WORD1: key_word1_reg <= cfg_wdata;
                CFG_KEY_WORD2: key_word2_reg <= cfg_wdata;
                CFG_KEY_WORD3: key_word3_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Key size three behaves as a 256-bit key.
    always_comb begin
        unique case (key_size_reg)
            2'd0: nr = 4'd10;
            2'd1: nr = 4'd12;
            default: nr = 4'd14;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign ks_start = accept && s_tuser == OP_LOAD_IV;
    assign out_free = !m_valid_reg || m_tready;

    // The schedule fills the memory only during a key load and the rounds read it
    // only during an encrypt, so reads and writes never overlap on one entry.
    acbc_key_sched u_key_sched (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ks_start),
        .key_size  (key_size_reg),
        .key_word0 (key_word0_reg),
        .key_word1 (key_word1_reg),
        .key_word2 (key_word2_reg),
        .key_word3 (key_word3_reg),
        .done      (ks_done),
        .rk_wr     (rk_wr)
    );

    acbc_ram #(
        .WIDTH (RK_W),
        .DEPTH (RK_DEPTH)
    ) u_rk_ram (
        .aclk  (aclk),
        .we    (rk_wr.en),
        .waddr (rk_wr.addr),
        .wdata (rk_wr.data),
        .raddr (rd_addr),
        .rdata (rk_data)
    );

    always_comb begin
        state_next   = state_reg;
        rnd_next     = rnd_reg;
        chain0_next  = chain0_reg;
        chain1_next  = chain1_reg;
        s0_next      = s0_reg;
        s1_next      = s1_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        rd_addr      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    last_next = s_tlast;
                    rnd_next  = 4'd0;
                    if (s_tuser == OP_LOAD_IV) begin
                        chain0_next = {s_tdata[63:0], s_tdata[127:64]};
                        chain1_next = {s_tdata[191:128], s_tdata[255:192]};
                        state_next  = ST_EXPAND;
                    end else begin
                        s0_next    = {s_tdata[63:0], s_tdata[127:64]} ^ chain0_reg;
                        s1_next    = {s_tdata[191:128], s_tdata[255:192]} ^ chain1_reg;
                        state_next = ST_ENC;
                    end
                end
            end
            ST_EXPAND: begin
                if (ks_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ENC: begin
                // The key of this round was addressed in the previous cycle.
                if (rnd_reg == 4'd0) begin
                    s0_next = s0_reg ^ rk_data;
                    s1_next = s1_reg ^ rk_data;
                end else begin
                    s0_next = aes_round(s0_reg, rnd_reg == nr) ^ rk_data;
                    s1_next = aes_round(s1_reg, rnd_reg == nr) ^ rk_data;
                end
                if (rnd_reg == nr) begin
                    chain0_next = s0_next;
                    chain1_next = s1_next;
                    state_next  = ST_WAIT;
                end else begin
                    rnd_next = rnd_reg + 4'd1;
                    rd_addr  = RK_AW'(rnd_reg + 4'd1);
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {chain1_reg[63:0], chain1_reg[127:64],
                                    chain0_reg[63:0], chain0_reg[127:64]};
                    m_last_next  = last_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            chain0_reg  <= '0;
            chain1_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            chain0_reg  <= chain0_next;
            chain1_reg  <= chain1_next;
        end
        rnd_reg    <= rnd_next;
        s0_reg     <= s0_next;
        s1_reg     <= s1_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_wr_only_expand: assert property (@(posedge aclk) disable iff (!aresetn)
        rk_wr.en |-> state_reg == ST_EXPAND)
        else $error("round-key write outside key expansion");
    a_rnd_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ENC |-> rnd_reg <= nr)
        else $error("round counter ran past the round count");
    a_final_to_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ENC && rnd_reg == nr) |=> state_reg == ST_WAIT)
        else $error("final round did not hand off to output");
    a_result_only_after_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_WAIT)
        else $error("result appeared without a finished encrypt");
`endif
endmodule
`default_nettype wire
